>>> hdl/bpr_pkg.sv
// Package with the shared types and constants of the binomial coefficient unit.
package bpr_pkg;

    localparam int MAX_COL_DEF = 31;
    localparam int MAX_ROW_DEF = 511;

    localparam int ROW_W  = 9;
    localparam int COL_W  = 5;
    localparam int COEF_W = 31;

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    typedef struct packed {
        logic [ROW_W-1:0] row_n;
        logic [COL_W-1:0] col_k;
    } in_word_t;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              overflow;
    } out_word_t;

    // One entry of the scratch row: saturation mark and value.
    typedef struct packed {
        logic              sat;
        logic [COEF_W-1:0] value;
    } cell_t;

endpackage

>>> hdl/bpr_row_store.sv
// Scratch row memory with per-entry valid bits and a registered read port.
module bpr_row_store #(
    parameter int DEPTH = bpr_pkg::MAX_COL_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [AW-1:0]       rd_addr,
    output bpr_pkg::cell_t      rd_cell,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bpr_pkg::cell_t      wr_cell
);

    bpr_pkg::cell_t    row_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    bpr_pkg::cell_t    rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_cell;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b1;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            rd_zero_reg  <= (rd_addr == '0);
        end
    end

    // An entry not written since the last clear reads as one in cell zero and zero elsewhere.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_cell = rd_data_reg;
        end
        else
        begin
            rd_cell.sat   = 1'b0;
            rd_cell.value = rd_zero_reg ? bpr_pkg::COEF_W'(1) : '0;
        end
    end

endmodule

>>> hdl/binomial_pascal_row_unit.sv
// Top level of the binomial coefficient unit built on Pascal's rule.
// A request (row_n, col_k) is taken when start is high and busy is low, and one
// result word appears later on result, marked by done for a single cycle. The
// unit works one request at a time: for each row i from 1 to n it sweeps cells
// min(i,k) down to 1 through a scratch memory with one read and one write port,
// one cell addition per cycle within a sweep, with n held to MAX_ROW. A request
// with a lower index of zero or an upper index of zero skips the sweep. Sums
// saturate at 2^31-1 and set overflow. The next request may be given in the
// cycle in which done is high.
module binomial_pascal_row_unit #(
    parameter int MAX_COL = bpr_pkg::MAX_COL_DEF,
    parameter int MAX_ROW = bpr_pkg::MAX_ROW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bpr_pkg::in_word_t   req,
    output logic                done,
    output bpr_pkg::out_word_t  result
);

    localparam int DEPTH = MAX_COL + 1;
    localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROW + 1);
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int NW    = (RW > bpr_pkg::ROW_W) ? RW : bpr_pkg::ROW_W;
    localparam int KW    = (CW > bpr_pkg::COL_W) ? CW : bpr_pkg::COL_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_RDK   = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [RW-1:0]       n_reg, n_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [RW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                zero_reg, zero_next;
    bpr_pkg::cell_t      hi_reg, hi_next;
    logic                done_reg, done_next;
    bpr_pkg::out_word_t  result_reg, result_next;

    logic                clear;
    logic [CW-1:0]       rd_addr;
    bpr_pkg::cell_t      rd_cell;
    logic                wr_en;
    logic [CW-1:0]       wr_addr;
    bpr_pkg::cell_t      wr_cell;

    logic [NW-1:0]       n_ext;
    logic [KW-1:0]       k_ext;
    logic [RW-1:0]       n_sat;
    logic [MW-1:0]       i_cmp, k_cmp, top_cmp;
    logic [CW-1:0]       top;
    logic [bpr_pkg::COEF_W:0] sum;
    logic                sum_sat;

    bpr_row_store #(
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_addr (rd_addr),
        .rd_cell (rd_cell),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_cell (wr_cell)
    );

    assign n_ext   = NW'(req.row_n);
    assign k_ext   = KW'(req.col_k);
    assign n_sat   = (n_ext > NW'(MAX_ROW)) ? RW'(MAX_ROW) : n_ext[RW-1:0];
    assign i_cmp   = MW'(i_reg);
    assign k_cmp   = MW'(k_reg);
    assign top_cmp = (i_cmp < k_cmp) ? i_cmp : k_cmp;
    assign top     = top_cmp[CW-1:0];

    // hi_reg holds the old value of cell j, rd_cell the old value of cell j-1.
    assign sum     = {1'b0, hi_reg.value} + {1'b0, rd_cell.value};
    assign sum_sat = hi_reg.sat | rd_cell.sat | sum[bpr_pkg::COEF_W];

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        zero_next   = zero_reg;
        hi_next     = hi_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        clear       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = j_reg;
        wr_cell.sat   = sum_sat;
        wr_cell.value = sum_sat ? bpr_pkg::COEF_MAX : sum[bpr_pkg::COEF_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    clear  = 1'b1;
                    n_next = n_sat;
                    k_next = k_ext[CW-1:0];
                    i_next = RW'(1);
                    if (k_ext > KW'(MAX_COL))
                    begin
                        zero_next  = 1'b1;
                        state_next = ST_RDK;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        if ((n_sat == '0) || (k_ext == '0))
                        begin
                            state_next = ST_RDK;
                        end
                        else
                        begin
                            state_next = ST_ROW;
                        end
                    end
                end
            end
            ST_ROW:
            begin
                rd_addr    = top;
                j_next     = top;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rd_addr    = j_reg - CW'(1);
                hi_next    = rd_cell;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                hi_next = rd_cell;
                if (j_reg == CW'(1))
                begin
                    if (i_reg == n_reg)
                    begin
                        state_next = ST_RDK;
                    end
                    else
                    begin
                        i_next     = i_reg + RW'(1);
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    j_next  = j_reg - CW'(1);
                    rd_addr = j_reg - CW'(2);
                end
            end
            ST_RDK:
            begin
                rd_addr    = zero_reg ? '0 : k_reg;
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                done_next = 1'b1;
                if (zero_reg)
                begin
                    result_next.coefficient = '0;
                    result_next.overflow    = 1'b0;
                end
                else
                begin
                    result_next.coefficient = rd_cell.value;
                    result_next.overflow    = rd_cell.sat;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        zero_reg   <= zero_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_done_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINAL))
        else $error("done without a final state");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_no_write_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("write to the fixed cell zero");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (result.coefficient == bpr_pkg::COEF_MAX))
        else $error("overflow without saturated coefficient");
`endif

endmodule
